[design/signed_vlq_codec_defines.svh]
// Assertion macros used by the signed VLQ codec module.
`ifndef SIGNED_VLQ_CODEC_DEFINES_SVH
`define SIGNED_VLQ_CODEC_DEFINES_SVH

// Checked on every rising clock edge while reset is released.
`define SVLQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("signed_vlq_codec assertion failed");

// Checked on every rising clock edge, during reset as well.
`define SVLQ_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("signed_vlq_codec assertion failed");

`endif

[design/svlq_pkg.sv]
// Package with the types, constants and helpers of the signed VLQ codec.
`timescale 1ns / 1ps
package svlq_pkg;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned GroupWidth = 7;

  // Signed range limits for one to four byte encodings.
  localparam logic signed [ValueWidth-1:0] Hi1 = 32'sd96;
  localparam logic signed [ValueWidth-1:0] Lo1 = -32'sd32;
  localparam logic signed [ValueWidth-1:0] Hi2 = 32'sd12288;
  localparam logic signed [ValueWidth-1:0] Lo2 = -32'sd4096;
  localparam logic signed [ValueWidth-1:0] Hi3 = 32'sd1572864;
  localparam logic signed [ValueWidth-1:0] Lo3 = -32'sd524288;
  localparam logic signed [ValueWidth-1:0] Hi4 = 32'sd201326592;
  localparam logic signed [ValueWidth-1:0] Lo4 = -32'sd67108864;

  localparam logic [2:0] MaxRemain = 3'd4;

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [ByteWidth-1:0]  byte_t;
  typedef logic [2:0]            remain_t;

  // Number of bytes that follow the first one for a given value.
  function automatic remain_t bytes_after_first(input value_t v);
    logic signed [ValueWidth-1:0] sv;
    remain_t                      r;
    sv = $signed(v);
    if (sv < Hi1 && sv >= Lo1) begin
      r = 3'd0;
    end else if (sv < Hi2 && sv >= Lo2) begin
      r = 3'd1;
    end else if (sv < Hi3 && sv >= Lo3) begin
      r = 3'd2;
    end else if (sv < Hi4 && sv >= Lo4) begin
      r = 3'd3;
    end else begin
      r = MaxRemain;
    end
    return r;
  endfunction

endpackage

[design/svlq_if.sv]
// Valid/ready channel interfaces for the input and result items of the codec.
`timescale 1ns / 1ps
interface svlq_in_if;
  logic                          valid;
  logic                          ready;
  svlq_pkg::op_e                 op;
  logic [svlq_pkg::ValueWidth-1:0] value;
  logic [svlq_pkg::ByteWidth-1:0]  in_byte;

  modport source (output valid, output op, output value, output in_byte, input ready);
  modport sink   (input valid, input op, input value, input in_byte, output ready);
endinterface

interface svlq_out_if;
  logic                          valid;
  logic                          ready;
  logic [svlq_pkg::ByteWidth-1:0]  out_byte;
  logic [svlq_pkg::ValueWidth-1:0] out_value;
  logic                          last;

  modport source (output valid, output out_byte, output out_value, output last, input ready);
  modport sink   (input valid, input out_byte, input out_value, input last, output ready);
endinterface

[design/signed_vlq_codec.sv]
// An item in the item register reaches the port through the output register; a decode byte
// with the continuation flag set only updates the decoder state. An encode item holds the item
// register until all of its bytes, one to five, are emitted by the single byte emitter.
// The output register lets a new item enter while a finished result waits.
// Reset (asynchronous, active low) empties both registers and clears the decoder state.
// Decoder state survives encode items, so encodes may be interleaved with a decode.
`timescale 1ns / 1ps
`include "signed_vlq_codec_defines.svh"
module signed_vlq_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  svlq_in_if.sink    in_i,
  svlq_out_if.source out_o
);
  import svlq_pkg::*;

  logic    hold_valid_q, hold_valid_d;
  op_e     hold_op_q, hold_op_d;
  value_t  hold_value_q, hold_value_d;
  byte_t   hold_byte_q, hold_byte_d;
  remain_t rem_q, rem_d;

  value_t  acc_q, acc_d;
  logic    mid_q, mid_d;

  logic    out_valid_q, out_valid_d;
  byte_t   out_byte_q, out_byte_d;
  value_t  out_value_q, out_value_d;
  logic    out_last_q, out_last_d;

  logic    out_free;
  logic    step;
  logic    item_done;
  logic    take;
  logic    ext;
  value_t  dec_value;
  logic [GroupWidth-1:0] group;

  assign out_free = !out_valid_q || out_o.ready;
  assign step     = hold_valid_q &&
                    (out_free || (hold_op_q == OP_DECODE && hold_byte_q[ByteWidth-1]));
  assign item_done = (hold_op_q == OP_DECODE) || (rem_q == 3'd0);
  assign in_i.ready = !hold_valid_q || (step && item_done);
  assign take = in_i.valid && in_i.ready;

  assign ext       = hold_byte_q[6] & hold_byte_q[5];
  assign dec_value = mid_q ? {acc_q[ValueWidth-GroupWidth-1:0], hold_byte_q[GroupWidth-1:0]}
                           : {{(ValueWidth-GroupWidth){ext}}, hold_byte_q[GroupWidth-1:0]};

  always_comb begin
    case (rem_q)
      3'd0:    group = hold_value_q[6:0];
      3'd1:    group = hold_value_q[13:7];
      3'd2:    group = hold_value_q[20:14];
      3'd3:    group = hold_value_q[27:21];
      3'd4:    group = {3'b000, hold_value_q[31:28]};
      default: group = '0;
    endcase
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    hold_op_d    = hold_op_q;
    hold_value_d = hold_value_q;
    hold_byte_d  = hold_byte_q;
    rem_d        = rem_q;
    acc_d        = acc_q;
    mid_d        = mid_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_byte_d   = out_byte_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;

    if (step) begin
      if (hold_op_q == OP_DECODE) begin
        if (hold_byte_q[ByteWidth-1]) begin
          acc_d = dec_value;
          mid_d = 1'b1;
        end else begin
          acc_d       = '0;
          mid_d       = 1'b0;
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          out_value_d = dec_value;
          out_last_d  = 1'b1;
        end
      end else begin
        out_valid_d = 1'b1;
        out_byte_d  = {(rem_q != 3'd0), group};
        out_value_d = '0;
        out_last_d  = (rem_q == 3'd0);
        rem_d       = rem_q - 3'd1;
      end
      if (item_done) begin
        hold_valid_d = 1'b0;
      end
    end

    if (take) begin
      hold_valid_d = 1'b1;
      hold_op_d    = in_i.op;
      hold_value_d = in_i.value;
      hold_byte_d  = in_i.in_byte;
      rem_d        = bytes_after_first(in_i.value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      acc_q        <= '0;
      mid_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      acc_q        <= acc_d;
      mid_q        <= mid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_op_q    <= hold_op_d;
    hold_value_q <= hold_value_d;
    hold_byte_q  <= hold_byte_d;
    rem_q        <= rem_d;
    out_byte_q   <= out_byte_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.out_value = out_value_q;
  assign out_o.last      = out_last_q;

  `SVLQ_ASSERT(a_rem_range, clk_i, rst_ni,
      hold_valid_q && hold_op_q == OP_ENCODE |-> rem_q <= MaxRemain)
  `SVLQ_ASSERT(a_busy_blocks_input, clk_i, rst_ni,
      hold_valid_q && !(step && item_done) |-> !in_i.ready)
  `SVLQ_ASSERT(a_continuation_flag, clk_i, rst_ni,
      out_valid_q && !out_last_q |-> out_byte_q[ByteWidth-1])
  `SVLQ_ASSERT(a_decode_clears_state, clk_i, rst_ni,
      step && hold_op_q == OP_DECODE && !hold_byte_q[ByteWidth-1]
      |=> !mid_q && acc_q == '0)
  `SVLQ_ASSERT_ALWAYS(a_reset_empty, clk_i,
      !rst_ni |=> !out_valid_q && !hold_valid_q)

endmodule
